// ===== design/bda_pkg.sv =====
// ----------------------------------------------------------------------------
// bda_pkg
// Shared types and constants for the packed-BCD arithmetic unit.
// ----------------------------------------------------------------------------
package bda_pkg;

    localparam int DIGITS_MAX = 16;
    localparam int DIGITS_DEF = 16;
    localparam int WORD_W     = 4 * DIGITS_MAX;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_MOD = 3'd4,
        OP_LT  = 3'd5,
        OP_EQ  = 3'd6,
        OP_NOP = 3'd7
    } t_op;

    typedef struct packed {
        logic [2:0]        op;
        logic [WORD_W-1:0] operand_a;
        logic [WORD_W-1:0] operand_b;
    } t_req;

    typedef struct packed {
        logic [WORD_W-1:0] result_bcd;
        logic              compare_true;
        logic              carry_or_borrow;
        logic              overflow;
        logic              div_by_zero;
        logic              bad_digit;
    } t_rsp;

endpackage

// ===== design/bcd_decimal_alu_core.sv =====
// ----------------------------------------------------------------------------
// bcd_decimal_alu_core
// Packed-BCD add, subtract, multiply, divide, remainder and compare.
// ----------------------------------------------------------------------------
// Usage: present a request (op, operand_a, operand_b) with i_valid; it is
// taken at an edge with i_valid high and o_stall low. The result appears on
// o_valid/o_rsp and holds while i_stall is high. A new request is taken
// only once the previous result has been taken.
// All work runs through one shared DIGITS-digit decimal adder/subtractor
// (one digit position per cycle, ripple over the digit counter).
//   add, sub, compare: one pass of the adder over all DIGITS digits.
//   mul: DIGITS multiplier digits, each a shift and up to 9 adds of a.
//   div, mod: DIGITS quotient digits, each a shift and up to 10 trial
//        subtracts of b.
// Reset clears the sequencer and drops any pending result.
// ----------------------------------------------------------------------------
module bcd_decimal_alu_core #(
    parameter int DIGITS = bda_pkg::DIGITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  bda_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_stall,
    output bda_pkg::t_rsp o_rsp
);
    import bda_pkg::*;

    localparam int W   = 4 * DIGITS;
    localparam int DW  = $clog2(DIGITS + 1);
    localparam int AW  = 2 * W;

    typedef enum logic [2:0] {
        S_IDLE, S_PASS, S_MSTEP, S_DSTEP, S_DONE
    } t_state;

    t_state        r_state;
    t_op           r_op;
    logic [W-1:0]  r_a, r_b;
    logic [AW-1:0] r_acc;          // mul: product, div: {rem, quot}
    logic [W-1:0]  r_x, r_y, r_sum;
    logic          r_sub, r_cy;
    logic [DW-1:0] r_pos;
    logic [DW-1:0] r_dig;
    logic [3:0]    r_cnt;
    logic          r_busy_add;
    t_rsp          r_rsp;
    logic          r_ovalid;

    // shared digit adder/subtractor
    logic [3:0] s_xd, s_yd, s_dd;
    logic [4:0] s_raw;
    logic       s_co;
    always_comb begin
        s_xd = r_x[r_pos[DW-1:0]*4 +: 4];
        s_yd = r_y[r_pos[DW-1:0]*4 +: 4];
        if (r_sub) begin
            s_raw = {1'b0, s_xd} - {1'b0, s_yd} - {4'd0, r_cy};
            s_co  = s_raw[4];
            s_dd  = s_co ? 4'(s_raw + 5'd10) : s_raw[3:0];
        end else begin
            s_raw = {1'b0, s_xd} + {1'b0, s_yd} + {4'd0, r_cy};
            s_co  = s_raw > 5'd9;
            s_dd  = s_co ? 4'(s_raw - 5'd10) : s_raw[3:0];
        end
    end

    logic s_bad;
    always_comb begin
        s_bad = 1'b0;
        for (int i = 0; i < DIGITS; i++) begin
            if (i_req.operand_a[4*i +: 4] > 4'd9) s_bad = 1'b1;
            if (i_req.operand_b[4*i +: 4] > 4'd9) s_bad = 1'b1;
        end
    end

    logic [DW-1:0] DLAST;
    assign DLAST = DW'(DIGITS - 1);

    logic [W-1:0] s_rem;
    assign s_rem = r_acc[AW-1 -: W];

    assign o_stall = (r_state != S_IDLE) || r_ovalid;
    assign o_valid = r_ovalid;
    always_comb begin
        o_rsp = r_rsp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ovalid   <= 1'b0;
            r_busy_add <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            // digit ripple of the shared adder
            if (r_busy_add) begin
                r_sum[r_pos*4 +: 4] <= s_dd;
                r_cy <= s_co;
                if (r_pos == DLAST) r_busy_add <= 1'b0;
                else r_pos <= r_pos + 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && !r_ovalid) begin
                        r_op  <= t_op'(i_req.op);
                        r_a   <= i_req.operand_a[W-1:0];
                        r_b   <= i_req.operand_b[W-1:0];
                        r_rsp <= '0;
                        r_pos <= '0;
                        r_cy  <= 1'b0;
                        r_dig <= '0;
                        r_cnt <= '0;
                        r_acc <= '0;
                        if (s_bad) begin
                            r_rsp.bad_digit <= 1'b1;
                            r_state <= S_DONE;
                        end else begin
                            unique case (t_op'(i_req.op))
                                OP_ADD, OP_SUB, OP_LT, OP_EQ: begin
                                    r_x <= i_req.operand_a[W-1:0];
                                    r_y <= i_req.operand_b[W-1:0];
                                    r_sub <= (i_req.op != OP_ADD);
                                    r_busy_add <= 1'b1;
                                    r_state <= S_PASS;
                                end
                                OP_MUL: begin
                                    r_state <= S_MSTEP;
                                end
                                OP_DIV, OP_MOD: begin
                                    if (i_req.operand_b[W-1:0] == '0) begin
                                        r_rsp.div_by_zero <= 1'b1;
                                        if (i_req.op == OP_MOD)
                                            r_rsp.result_bcd <= 64'(i_req.operand_a[W-1:0]);
                                        r_state <= S_DONE;
                                    end else begin
                                        r_acc <= AW'(i_req.operand_a[W-1:0]);
                                        r_state <= S_DSTEP;
                                    end
                                end
                                default: r_state <= S_DONE;
                            endcase
                        end
                    end
                end
                S_PASS: begin
                    if (!r_busy_add && r_pos == DLAST && r_cnt == 4'd0) begin
                        r_cnt <= 4'd1;
                    end else if (r_cnt == 4'd1) begin
                        unique case (r_op)
                            OP_ADD, OP_SUB: begin
                                r_rsp.result_bcd      <= 64'(r_sum);
                                r_rsp.carry_or_borrow <= r_cy;
                            end
                            OP_LT: r_rsp.compare_true <= r_cy;
                            default: r_rsp.compare_true <= (r_sum == '0);
                        endcase
                        r_state <= S_DONE;
                    end
                end
                S_MSTEP: begin
                    // acc = acc*10 + a*b[digit], digit from the top
                    if (r_busy_add) begin
                    end else if (r_cnt == 4'd0) begin
                        r_acc <= r_acc << 4;
                        if (r_acc[AW-1 -: 4] != 4'd0) r_rsp.overflow <= 1'b1;
                        r_x   <= '0;
                        r_cnt <= 4'd1;
                    end else if (r_cnt == 4'd1) begin
                        // prime a low-half accumulation loop
                        r_x   <= r_acc[W-1:0];
                        r_cnt <= 4'd2;
                        r_sum <= r_acc[W-1:0];
                    end else begin
                        if (r_cnt != 4'd2) begin
                            // one add finished: a carry out of the low half overflows
                            r_acc[W-1:0] <= r_sum;
                            if (r_cy) r_rsp.overflow <= 1'b1;
                        end
                        if (4'(r_cnt - 4'd2) <
                            r_b[(DIGITS-1-int'(r_dig))*4 +: 4]) begin
                            r_x <= (r_cnt == 4'd2) ? r_acc[W-1:0] : r_sum;
                            r_y <= r_a;
                            r_sub <= 1'b0;
                            r_cy <= 1'b0;
                            r_pos <= '0;
                            r_busy_add <= 1'b1;
                            r_cnt <= r_cnt + 4'd1;
                        end else if (r_dig == DLAST) begin
                            r_rsp.result_bcd <= 64'((r_cnt == 4'd2) ?
                                                    r_acc[W-1:0] : r_sum);
                            if (r_acc[AW-1:W] != '0) r_rsp.overflow <= 1'b1;
                            r_state <= S_DONE;
                        end else begin
                            r_dig <= r_dig + 1'b1;
                            r_cnt <= 4'd0;
                        end
                    end
                end
                S_DSTEP: begin
                    // r_acc = {rem, quot}; shift one digit, then subtract b
                    if (r_busy_add) begin
                    end else if (r_cnt == 4'd0) begin
                        r_acc <= r_acc << 4;
                        r_cnt <= 4'd1;
                    end else begin
                        if (r_cnt != 4'd1) begin
                            if (!r_cy) begin
                                r_acc[AW-1 -: W] <= r_sum;
                                r_acc[3:0] <= r_acc[3:0] + 4'd1;
                            end
                        end
                        if (r_cnt != 4'd1 && r_cy) begin
                            if (r_dig == DLAST) begin
                                r_rsp.result_bcd <= 64'((r_op == OP_DIV) ?
                                                        r_acc[W-1:0] : s_rem);
                                r_state <= S_DONE;
                            end else begin
                                r_dig <= r_dig + 1'b1;
                                r_cnt <= 4'd0;
                            end
                        end else begin
                            r_x <= (r_cnt == 4'd1) ? s_rem : r_sum;
                            r_y <= r_b;
                            r_sub <= 1'b1;
                            r_cy <= 1'b0;
                            r_pos <= '0;
                            r_busy_add <= 1'b1;
                            r_cnt <= 4'd2;
                        end
                    end
                end
                S_DONE: begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    ap_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall) else $error("accept while busy");
    ap_done_to_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> o_valid) else $error("result lost");
    ap_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.bad_digit) |-> (o_rsp.result_bcd == '0))
        else $error("bad digit with result");

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for bcd_decimal_alu_core: a table of directed requests
// followed by random requests, mostly packed BCD, with random idling on both sides,
// one long hold-off of the result side, and a predictor compared per field.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import bda_pkg::*;

    localparam int NDIG     = 16;
    localparam int N_RANDOM = 400;

    typedef struct {
        t_op            op;
        logic [63:0]    a;
        logic [63:0]    b;
        bit             known;
        t_rsp           rsp;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    t_req i_req = '0;
    logic o_stall;
    logic o_valid;
    t_rsp o_rsp;

    t_rsp alu_expected_q[$];
    int   n_errors = 0;
    bit   send_done = 1'b0;
    bit   hold_off = 1'b0;

    bcd_decimal_alu_core #(.DIGITS(NDIG)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_req  (i_req),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_rsp  (o_rsp)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [63:0] bcd_of(input logic [63:0] v);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < NDIG; i++) begin
            r[4*i +: 4] = 4'(v % 10);
            v = v / 10;
        end
        return r;
    endfunction

    function automatic t_rsp bcd_alu_predict(input t_op op, input logic [63:0] ra,
                                             input logic [63:0] rb);
        t_rsp        r;
        logic [63:0] a, b, lim, s;
        int unsigned acc[2*NDIG];
        int unsigned carry;
        bit          bad;
        r = '0;
        a = 0;
        b = 0;
        lim = 1;
        bad = 1'b0;
        for (int i = NDIG - 1; i >= 0; i--) begin
            if (ra[4*i +: 4] > 9 || rb[4*i +: 4] > 9) bad = 1'b1;
            a = a * 10 + ra[4*i +: 4];
            b = b * 10 + rb[4*i +: 4];
            lim = lim * 10;
        end
        if (bad) begin
            r.bad_digit = 1'b1;
            return r;
        end
        case (op)
            OP_ADD: begin
                s = a + b;
                if (s >= lim) begin
                    s = s - lim;
                    r.carry_or_borrow = 1'b1;
                end
                r.result_bcd = bcd_of(s);
            end
            OP_SUB: begin
                if (a < b) begin
                    r.carry_or_borrow = 1'b1;
                    r.result_bcd = bcd_of(lim - b + a);
                end else begin
                    r.result_bcd = bcd_of(a - b);
                end
            end
            OP_MUL: begin
                foreach (acc[i]) acc[i] = 0;
                for (int i = 0; i < NDIG; i++)
                    for (int j = 0; j < NDIG; j++)
                        acc[i+j] += ra[4*i +: 4] * rb[4*j +: 4];
                carry = 0;
                for (int i = 0; i < 2*NDIG; i++) begin
                    acc[i] += carry;
                    carry = acc[i] / 10;
                    acc[i] = acc[i] % 10;
                end
                for (int i = 0; i < NDIG; i++) r.result_bcd[4*i +: 4] = 4'(acc[i]);
                for (int i = NDIG; i < 2*NDIG; i++)
                    if (acc[i] != 0) r.overflow = 1'b1;
            end
            OP_DIV: begin
                if (b == 0) r.div_by_zero = 1'b1;
                else r.result_bcd = bcd_of(a / b);
            end
            OP_MOD: begin
                if (b == 0) begin
                    r.div_by_zero = 1'b1;
                    r.result_bcd = bcd_of(a);
                end else begin
                    r.result_bcd = bcd_of(a % b);
                end
            end
            OP_LT: r.compare_true = a < b;
            OP_EQ: r.compare_true = a == b;
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [63:0] rand_bcd(input int ndig);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < ndig; i++) v[4*i +: 4] = 4'($urandom_range(9, 0));
        return v;
    endfunction

    function automatic t_rsp mk(input logic [63:0] res, input bit cmp, input bit cb,
                                input bit ov, input bit dz, input bit bd);
        t_rsp r;
        r.result_bcd = res;
        r.compare_true = cmp;
        r.carry_or_borrow = cb;
        r.overflow = ov;
        r.div_by_zero = dz;
        r.bad_digit = bd;
        return r;
    endfunction

    task automatic send_request(input t_op op, input logic [63:0] a, input logic [63:0] b,
                                input t_rsp expected_rsp);
        while (!hold_off && $urandom_range(99, 0) < 16) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_req <= '{op: op, operand_a: a, operand_b: b};
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        alu_expected_q.push_back(expected_rsp);
        @(negedge i_clk);
    endtask

    t_row dir_rows[$];

    initial begin
        t_row        row;
        logic [63:0] nines, a, b;
        t_op         op;
        t_rsp        e;
        int          kind, nd;
        nines = 64'h9999_9999_9999_9999;
        dir_rows = '{
            '{OP_ADD, 64'h0, 64'h0, 1, mk(64'h0, 0, 0, 0, 0, 0)},
            '{OP_ADD, nines, 64'h1, 1, mk(64'h0, 0, 1, 0, 0, 0)},
            '{OP_ADD, nines, nines, 0, '0},
            '{OP_SUB, 64'h0, 64'h1, 1, mk(nines, 0, 1, 0, 0, 0)},
            '{OP_SUB, nines, nines, 1, mk(64'h0, 0, 0, 0, 0, 0)},
            '{OP_SUB, 64'h1234, 64'h987, 0, '0},
            '{OP_MUL, nines, nines, 0, '0},
            '{OP_MUL, 64'h0, nines, 1, mk(64'h0, 0, 0, 0, 0, 0)},
            '{OP_MUL, 64'h12345, 64'h678, 0, '0},
            '{OP_DIV, nines, 64'h0, 1, mk(64'h0, 0, 0, 0, 1, 0)},
            '{OP_DIV, nines, 64'h7, 0, '0},
            '{OP_DIV, 64'h5, nines, 1, mk(64'h0, 0, 0, 0, 0, 0)},
            '{OP_MOD, 64'h4321, 64'h0, 1, mk(64'h4321, 0, 0, 0, 1, 0)},
            '{OP_MOD, nines, 64'h13, 0, '0},
            '{OP_LT, 64'h1, 64'h2, 1, mk(64'h0, 1, 0, 0, 0, 0)},
            '{OP_LT, nines, nines, 1, mk(64'h0, 0, 0, 0, 0, 0)},
            '{OP_EQ, nines, nines, 1, mk(64'h0, 1, 0, 0, 0, 0)},
            '{OP_EQ, 64'h0, 64'h1, 1, mk(64'h0, 0, 0, 0, 0, 0)},
            '{OP_NOP, nines, 64'h5, 1, mk(64'h0, 0, 0, 0, 0, 0)},
            '{OP_ADD, 64'hA, 64'h1, 1, mk(64'h0, 0, 0, 0, 0, 1)},
            '{OP_MUL, 64'h1, 64'hF000_0000_0000_0000, 1, mk(64'h0, 0, 0, 0, 0, 1)},
            '{OP_DIV, {16{4'hF}}, 64'h0, 1, mk(64'h0, 0, 0, 0, 0, 1)}
        };
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            e = row.known ? row.rsp : bcd_alu_predict(row.op, row.a, row.b);
            send_request(row.op, row.a, row.b, e);
        end
        for (int n = 0; n < N_RANDOM; n++) begin
            op = t_op'($urandom_range(7, 0));
            kind = $urandom_range(99, 0);
            nd = (kind < 60) ? $urandom_range(NDIG, 1) : NDIG;
            a = rand_bcd(nd);
            b = rand_bcd($urandom_range(NDIG, 0));
            if (kind < 8) a = {$urandom, $urandom};
            else if (kind < 14) b = {$urandom, $urandom};
            else if (kind < 18) b = '0;
            else if (kind < 22) b = a;
            else if (kind < 26) a = nines;
            send_request(op, a, b, bcd_alu_predict(op, a, b));
        end
        i_valid <= 1'b0;
        send_done = 1'b1;
    end

    initial begin
        int stretch;
        stretch = 0;
        wait (i_rst_n);
        repeat (3000) @(negedge i_clk);
        hold_off = 1'b1;
        i_stall <= 1'b1;
        repeat (4000) @(negedge i_clk);
        hold_off = 1'b0;
        forever begin
            @(negedge i_clk);
            stretch++;
            if (stretch > 30000 && stretch < 45000) i_stall <= 1'b0;
            else i_stall <= ($urandom_range(99, 0) < 16);
        end
    end

    always @(posedge i_clk) begin
        t_rsp e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (alu_expected_q.size() == 0) begin
                $display("%0t: unexpected result %p", $time, o_rsp);
                n_errors++;
            end else begin
                e = alu_expected_q.pop_front();
                if (o_rsp.result_bcd !== e.result_bcd) begin
                    $display("%0t: result_bcd expected %h actual %h", $time,
                             e.result_bcd, o_rsp.result_bcd);
                    n_errors++;
                end
                if (o_rsp.compare_true !== e.compare_true) begin
                    $display("%0t: compare_true expected %b actual %b", $time,
                             e.compare_true, o_rsp.compare_true);
                    n_errors++;
                end
                if (o_rsp.carry_or_borrow !== e.carry_or_borrow) begin
                    $display("%0t: carry_or_borrow expected %b actual %b", $time,
                             e.carry_or_borrow, o_rsp.carry_or_borrow);
                    n_errors++;
                end
                if (o_rsp.overflow !== e.overflow) begin
                    $display("%0t: overflow expected %b actual %b", $time,
                             e.overflow, o_rsp.overflow);
                    n_errors++;
                end
                if (o_rsp.div_by_zero !== e.div_by_zero) begin
                    $display("%0t: div_by_zero expected %b actual %b", $time,
                             e.div_by_zero, o_rsp.div_by_zero);
                    n_errors++;
                end
                if (o_rsp.bad_digit !== e.bad_digit) begin
                    $display("%0t: bad_digit expected %b actual %b", $time,
                             e.bad_digit, o_rsp.bad_digit);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        wait (send_done);
        while (alu_expected_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("bcd_decimal_alu_core regression: pass");
        end else begin
            $display("bcd_decimal_alu_core regression: fail");
        end
        $finish;
    end

    initial begin
        #100ms;
        $display("bcd_decimal_alu_core regression: fail");
        $finish;
    end
endmodule
